// File: sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the per-symbol trade statistics block.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 64;

   localparam int TIME_W  = 40;
   localparam int KEY_W   = 32;
   localparam int QTY_W   = 20;
   localparam int PRICE_W = 20;
   localparam int VOL_W   = 48;
   localparam int GAP_W   = 40;
   localparam int STAT_W  = 2;
   // numerator avg*vol + px*qty stays below 2^69
   localparam int NUM_W   = 69;
   localparam int DEN_W   = 49;

   localparam logic [STAT_W-1:0] ST_UPDATED = 2'd0;
   localparam logic [STAT_W-1:0] ST_CREATED = 2'd1;
   localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

   // divider control between top level and divider
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

// File: sv/pst_divider.sv
// ----------------------------------------------------------------------------
// pst_divider
// Restoring divider, one quotient bit per cycle; keeps the low price bits.
// ----------------------------------------------------------------------------
module pst_divider
   import pst_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     numerator,
   input  logic [DEN_W-1:0]     denominator,
   output div_ctrl_type         ctrl,
   output logic [PRICE_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W:0]     rem_ff, rem_in;
   logic [PRICE_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DEN_W:0]     shifted;

   // one shift/subtract step
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      if (start) begin
         num_in  = numerator;
         den_in  = denominator;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff};
            quo_in = {quo_ff[PRICE_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[PRICE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign quotient   = quo_ff;

endmodule

// File: sv/per_symbol_trade_statistics.sv
// Timing: a trade for an existing symbol goes through a key scan, a read, a multiply,
// a sum and a divide before rsp_valid rises; a new or dropped one goes from the key
// scan straight to raising rsp_valid.
// Throughput: one trade in work; the next is accepted only after the result is taken.
// Reset: valid bits clear at once; other memory contents stay undefined.
// ----------------------------------------------------------------------------
// per_symbol_trade_statistics
// Per-symbol volume, weighted average, top price and largest time gap.
// ----------------------------------------------------------------------------
module per_symbol_trade_statistics
   import pst_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TIME_W-1:0]   req_trade_time,
   input  logic [KEY_W-1:0]    req_symbol_code,
   input  logic [QTY_W-1:0]    req_quantity,
   input  logic [PRICE_W-1:0]  req_price,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [VOL_W-1:0]    rsp_total_volume,
   output logic [GAP_W-1:0]    rsp_largest_gap,
   output logic [PRICE_W-1:0]  rsp_average_price,
   output logic [PRICE_W-1:0]  rsp_highest_price
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int REC_W = VOL_W + GAP_W + TIME_W + 2 * PRICE_W;
   // volume split for the average-times-volume product
   localparam int VLO_W = 24;
   localparam int PP_W  = PRICE_W + VLO_W;
   localparam int PQ_W  = PRICE_W + QTY_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_CALC = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   localparam logic [2:0] S_SUM  = 3'd6;

   // memories
   logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
   logic [REC_W-1:0] rec_mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic [2:0]         state_ff;
   logic [TIME_W-1:0]  t_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic [PRICE_W-1:0] px_ff;
   logic [CNT_W-1:0]   scan_ff;     // address issued
   logic [IDX_W-1:0]   chk_ff;      // address whose data is on key_rd
   logic               chk_vld_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic [KEY_W-1:0]   key_rd;
   logic [REC_W-1:0]   rec_rd;
   logic [IDX_W-1:0]   rec_addr;
   logic               rec_we;
   logic [REC_W-1:0]   rec_wd;

   logic [VOL_W-1:0]   vol_ff;
   logic [GAP_W-1:0]   gap_ff;
   logic [PRICE_W-1:0] top_ff, avg_ff;
   logic [STAT_W-1:0]  stat_ff;
   logic [PP_W-1:0]    p_lo_ff, p_hi_ff;
   logic [PQ_W-1:0]    pq_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               div_start;
   div_ctrl_type       div_ctrl;
   logic [PRICE_W-1:0] div_q;

   // lowest free entry
   logic               free_any;
   logic [IDX_W-1:0]   free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // old record fields
   logic [VOL_W-1:0]   o_vol;
   logic [GAP_W-1:0]   o_gap;
   logic [TIME_W-1:0]  o_time;
   logic [PRICE_W-1:0] o_top, o_avg;
   assign {o_vol, o_gap, o_time, o_top, o_avg} = rec_rd;

   logic [DEN_W-1:0]   sum_vol;
   logic [TIME_W-1:0]  dt;
   assign sum_vol = {1'b0, o_vol} + DEN_W'(qty_ff);
   assign dt      = t_ff - o_time;

   assign req_ready = (state_ff == S_IDLE);
   // first cycle of the divide state: divider idle and not just finished
   assign div_start = (state_ff == S_DIV) && !div_ctrl.busy && !div_ctrl.done;
   assign rec_addr  = hit_idx_ff;

   always_ff @(posedge clock) begin
      key_rd <= key_mem[scan_ff[IDX_W-1:0]];
      rec_rd <= rec_mem[rec_addr];
      if (rec_we) begin
         rec_mem[hit_idx_ff] <= rec_wd;
      end
   end

   assign rec_we = (state_ff == S_OUT) && !rsp_valid && (stat_ff != ST_DROPPED);
   assign rec_wd = {vol_ff, gap_ff, t_ff, top_ff, avg_ff};

   pst_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num_ff),
      .denominator (den_ff),
      .ctrl        (div_ctrl),
      .quotient    (div_q)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         rsp_valid  <= 1'b0;
         chk_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
         scan_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  t_ff       <= req_trade_time;
                  key_ff     <= req_symbol_code;
                  qty_ff     <= req_quantity;
                  px_ff      <= req_price;
                  scan_ff    <= '0;
                  chk_vld_ff <= 1'b0;
                  hit_ff     <= 1'b0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               chk_ff     <= scan_ff[IDX_W-1:0];
               chk_vld_ff <= (scan_ff < CNT_W'(TABLE_ENTRIES));
               if (scan_ff < CNT_W'(TABLE_ENTRIES)) begin
                  scan_ff <= scan_ff + 1'b1;
               end
               if (chk_vld_ff && !hit_ff && valid_ff[chk_ff] && key_rd == key_ff) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= chk_ff;
               end
               if (!chk_vld_ff && scan_ff == CNT_W'(TABLE_ENTRIES)) begin
                  if (hit_ff) begin
                     state_ff <= S_READ;
                  end else if (free_any) begin
                     hit_idx_ff          <= free_idx;
                     valid_ff[free_idx]  <= 1'b1;
                     key_mem[free_idx]   <= key_ff;
                     stat_ff  <= ST_CREATED;
                     vol_ff   <= VOL_W'(qty_ff);
                     gap_ff   <= '0;
                     top_ff   <= px_ff;
                     avg_ff   <= px_ff;
                     state_ff <= S_OUT;
                  end else begin
                     stat_ff  <= ST_DROPPED;
                     vol_ff   <= '0;
                     gap_ff   <= '0;
                     top_ff   <= '0;
                     avg_ff   <= '0;
                     state_ff <= S_OUT;
                  end
               end
            end
            S_READ: begin
               state_ff <= S_CALC;
            end
            S_CALC: begin
               // rec_rd holds the hit entry now; partial products
               p_lo_ff <= PP_W'(o_avg) * PP_W'(o_vol[VLO_W-1:0]);
               p_hi_ff <= PP_W'(o_avg) * PP_W'(o_vol[VOL_W-1:VLO_W]);
               pq_ff   <= PQ_W'(px_ff) * PQ_W'(qty_ff);
               den_ff  <= sum_vol;
               vol_ff  <= sum_vol[VOL_W] ? '1 : sum_vol[VOL_W-1:0];
               top_ff  <= (px_ff > o_top) ? px_ff : o_top;
               gap_ff  <= (t_ff >= o_time && dt > o_gap) ? dt : o_gap;
               avg_ff  <= o_avg;
               stat_ff <= ST_UPDATED;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // numerator avg*vol + px*qty
               num_ff   <= (NUM_W'(p_hi_ff) << VLO_W) + NUM_W'(p_lo_ff) + NUM_W'(pq_ff);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_ctrl.done) begin
                  if (den_ff != '0) begin
                     avg_ff <= div_q;
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
               end else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_status        = stat_ff;
   assign rsp_total_volume  = vol_ff;
   assign rsp_largest_gap   = gap_ff;
   assign rsp_average_price = avg_ff;
   assign rsp_highest_price = top_ff;

endmodule

// File: sv/pst_checker.sv
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks of the trade statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module pst_checker
   import pst_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STAT_W-1:0]  rsp_status,
   input logic [VOL_W-1:0]   rsp_total_volume
);

   // one transaction in work: no new request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");

   // accepting a request closes the input side next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");

   // dropped results carry zero volume
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DROPPED) |-> rsp_total_volume == '0)
      else $error("dropped result has volume");

   // valid results carry a defined code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_UPDATED || rsp_status == ST_CREATED
                     || rsp_status == ST_DROPPED)) else $error("bad status");

   // held result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");

endmodule

bind per_symbol_trade_statistics pst_checker u_pst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_total_volume (rsp_total_volume)
);
